// ===== rtl/dtv_pkg.sv =====
package dtv_pkg;

    localparam int BIN_W       = 64;
    localparam int STAMP_BITS  = 57;
    localparam int BCD_DIGITS  = 17;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int DD_STEPS    = 8;
    localparam int DD_STAGES   = BIN_W / DD_STEPS;
    localparam int TOD_W       = 36;

    localparam logic [BIN_W-1:0] STAMP_MIN = 64'd10000000000000000;
    localparam logic [BIN_W-1:0] STAMP_MAX = 64'd99999999999999999;

    localparam logic [13:0] YEAR_FIRST = 14'd1970;
    localparam logic [13:0] YEAR_LAST  = 14'd9999;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_RANGE = 2'd1,
        FAULT_TIME  = 2'd2,
        FAULT_DATE  = 2'd3
    } fault_t;

    typedef struct packed {
        logic              rng_ok;
        logic [BIN_W-1:0]  bin;
        logic [BCD_W-1:0]  bcd;
    } dd_t;

    typedef struct packed {
        logic         stamp_ok;
        fault_t       fault_class;
        logic [13:0]  year_out;
        logic [3:0]   month_out;
        logic [4:0]   day_out;
        logic [4:0]   hour_out;
        logic [5:0]   minute_out;
        logic [5:0]   second_out;
        logic [9:0]   millis_out;
        logic [26:0]  trading_date;
        logic [TOD_W-1:0] time_bcd;
    } res_t;

    // one shift-add-3 step of binary to BCD
    function automatic logic [BCD_W-1:0] dabble_step(
        input logic [BCD_W-1:0] bcd,
        input logic             b
    );
        logic [BCD_W-1:0] adj;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage

// ===== rtl/dtv_range.sv =====
module dtv_range
    import dtv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BIN_W-1:0]  stamp_value,
    input  logic              en_down,
    output logic              en,
    output logic              valid,
    output dd_t               dd
);

    logic valid_reg;
    logic valid_next;
    dd_t  dd_reg;
    dd_t  dd_next;

    assign en = !valid_reg || en_down;

    always_comb
    begin
        valid_next     = en ? in_valid : valid_reg;
        dd_next.rng_ok = (stamp_value >= STAMP_MIN) && (stamp_value <= STAMP_MAX);
        dd_next.bin    = {{(BIN_W-STAMP_BITS){1'b0}}, stamp_value[STAMP_BITS-1:0]};
        dd_next.bcd    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg <= dd_next;
        end
    end

    assign valid = valid_reg;
    assign dd    = dd_reg;

endmodule

// ===== rtl/dtv_dabble_stage.sv =====
module dtv_dabble_stage
    import dtv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  dd_t   in_dd,
    input  logic  en_down,
    output logic  en,
    output logic  valid,
    output dd_t   dd
);

    logic valid_reg;
    logic valid_next;
    dd_t  dd_reg;
    dd_t  dd_next;
    logic digits_ok;

    assign en = !valid_reg || en_down;

    always_comb
    begin
        logic [BCD_W-1:0] b;
        b = in_dd.bcd;
        for (int k = 0; k < DD_STEPS; k++)
        begin
            b = dabble_step(b, in_dd.bin[BIN_W-1-k]);
        end
        valid_next     = en ? in_valid : valid_reg;
        dd_next.rng_ok = in_dd.rng_ok;
        dd_next.bin    = {in_dd.bin[BIN_W-DD_STEPS-1:0], {DD_STEPS{1'b0}}};
        dd_next.bcd    = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg <= dd_next;
        end
    end

    assign valid = valid_reg;
    assign dd    = dd_reg;

    always_comb
    begin
        digits_ok = 1'b1;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (dd_reg.bcd[4*d +: 4] > 4'd9)
            begin
                digits_ok = 1'b0;
            end
        end
    end

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> digits_ok)
        else $error("non-decimal digit in conversion stage");

endmodule

// ===== rtl/dtv_decode.sv =====
module dtv_decode
    import dtv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  dd_t   in_dd,
    input  logic  out_ready,
    output logic  en,
    output logic  out_valid,
    output res_t  res
);

    function automatic logic [6:0] bcd2(input logic [7:0] d);
        return 7'({3'd0, d[7:4]} * 7'd10 + {3'd0, d[3:0]});
    endfunction

    // first stage: digit fields to binary, time, year-range and leap checks
    logic        v9_reg;
    logic        v9_next;
    logic        rng9_reg;
    logic        time_ok9_reg;
    logic        yr_ok9_reg;
    logic        leap9_reg;
    logic [13:0] yy9_reg;
    logic [6:0]  mo9_reg;
    logic [6:0]  dd9_reg;
    logic [6:0]  hh9_reg;
    logic [6:0]  mi9_reg;
    logic [6:0]  ss9_reg;
    logic [9:0]  ms9_reg;
    logic [TOD_W-1:0] tod9_reg;

    logic        en9;
    logic        en10;
    logic [6:0]  hh_w;
    logic [6:0]  mi_w;
    logic [6:0]  ss_w;
    logic [9:0]  ms_w;
    logic [6:0]  ylo_w;
    logic [6:0]  yhi_w;
    logic [13:0] yy_w;

    // second stage: day limit, date value, fault priority
    logic        v10_reg;
    logic        v10_next;
    res_t        res_reg;
    res_t        res_next;
    logic [4:0]  lim_w;
    logic        date_ok_w;

    assign en10 = !v10_reg || out_ready;
    assign en9  = !v9_reg || en10;
    assign en   = en9;

    always_comb
    begin
        hh_w  = bcd2(in_dd.bcd[35:28]);
        mi_w  = bcd2(in_dd.bcd[27:20]);
        ss_w  = bcd2(in_dd.bcd[19:12]);
        ms_w  = 10'({6'd0, in_dd.bcd[11:8]} * 10'd100 + {3'd0, bcd2(in_dd.bcd[7:0])});
        ylo_w = bcd2(in_dd.bcd[59:52]);
        yhi_w = bcd2(in_dd.bcd[67:60]);
        yy_w  = 14'({7'd0, yhi_w} * 14'd100 + {7'd0, ylo_w});
        v9_next = en9 ? in_valid : v9_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en9)
        begin
            rng9_reg     <= in_dd.rng_ok;
            time_ok9_reg <= (hh_w < 7'd24) && (mi_w < 7'd60) && (ss_w <= 7'd60);
            yr_ok9_reg   <= (yy_w >= YEAR_FIRST) && (yy_w <= YEAR_LAST);
            leap9_reg    <= (ylo_w != 7'd0) ? (ylo_w[1:0] == 2'd0) : (yhi_w[1:0] == 2'd0);
            yy9_reg      <= yy_w;
            mo9_reg      <= bcd2(in_dd.bcd[51:44]);
            dd9_reg      <= bcd2(in_dd.bcd[43:36]);
            hh9_reg      <= hh_w;
            mi9_reg      <= mi_w;
            ss9_reg      <= ss_w;
            ms9_reg      <= ms_w;
            tod9_reg     <= in_dd.bcd[TOD_W-1:0];
        end
    end

    always_comb
    begin
        unique case (mo9_reg[3:0])
            4'd2:                      lim_w = leap9_reg ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   lim_w = 5'd30;
            default:                   lim_w = 5'd31;
        endcase
        date_ok_w = yr_ok9_reg && (mo9_reg >= 7'd1) && (mo9_reg <= 7'd12)
                    && (dd9_reg >= 7'd1) && (dd9_reg <= {2'd0, lim_w});

        res_next = '0;
        priority if (!rng9_reg)
        begin
            res_next.fault_class = FAULT_RANGE;
        end
        else if (!time_ok9_reg)
        begin
            res_next.fault_class = FAULT_TIME;
        end
        else if (!date_ok_w)
        begin
            res_next.fault_class = FAULT_DATE;
        end
        else
        begin
            res_next.stamp_ok     = 1'b1;
            res_next.fault_class  = FAULT_NONE;
            res_next.year_out     = yy9_reg;
            res_next.month_out    = mo9_reg[3:0];
            res_next.day_out      = dd9_reg[4:0];
            res_next.hour_out     = hh9_reg[4:0];
            res_next.minute_out   = mi9_reg[5:0];
            res_next.second_out   = ss9_reg[5:0];
            res_next.millis_out   = ms9_reg;
            res_next.trading_date = 27'({13'd0, yy9_reg} * 27'd10000
                                        + {20'd0, mo9_reg} * 27'd100 + {20'd0, dd9_reg});
            res_next.time_bcd     = tod9_reg;
        end
        v10_next = en10 ? v9_reg : v10_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            v9_reg  <= v9_next;
            v10_reg <= v10_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en10)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v10_reg;
    assign res       = res_reg;

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (v10_reg && res_reg.stamp_ok) |->
            (res_reg.fault_class == FAULT_NONE) && (res_reg.month_out >= 4'd1)
            && (res_reg.month_out <= 4'd12) && (res_reg.day_out != 5'd0))
        else $error("accepted stamp with bad fields");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v10_reg && !res_reg.stamp_ok) |->
            (res_reg.fault_class != FAULT_NONE) && (res_reg.year_out == 14'd0)
            && (res_reg.trading_date == 27'd0) && (res_reg.time_bcd == '0))
        else $error("rejected stamp with nonzero fields");

endmodule

// ===== rtl/decimal_timestamp_validator.sv =====
// Checks a binary value holding a 17-digit decimal timestamp YYYYMMDDHHMMSSmmm and returns
// stamp_ok, fault_class and the decoded fields, all fields zero when the stamp is rejected.
// One item per cycle is accepted while s_axis_tready is high. The stages are one input stage
// with the range compare, eight binary-to-BCD stages of eight shift-add-3 steps each, and two
// decode stages. Empty stages fill while the output is stalled, so s_axis_tready drops only
// when all 11 stages hold items.
module decimal_timestamp_validator
    import dtv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,   // [63:0] stamp_value
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,   // year_out, month_out, day_out, hour_out,
                                          // minute_out, second_out, millis_out,
                                          // trading_date, time_bcd, zero pad
    output logic [2:0]    m_axis_tuser    // stamp_ok, fault_class
);

    dd_t  dd_s  [0:DD_STAGES];
    logic vld_s [0:DD_STAGES];
    logic en_s  [0:DD_STAGES+1];
    res_t res;

    dtv_range u_range (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .stamp_value (s_axis_tdata),
        .en_down     (en_s[1]),
        .en          (en_s[0]),
        .valid       (vld_s[0]),
        .dd          (dd_s[0])
    );

    for (genvar g = 0; g < DD_STAGES; g++)
    begin : g_dabble
        dtv_dabble_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (vld_s[g]),
            .in_dd    (dd_s[g]),
            .en_down  (en_s[g+2]),
            .en       (en_s[g+1]),
            .valid    (vld_s[g+1]),
            .dd       (dd_s[g+1])
        );
    end

    dtv_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_s[DD_STAGES]),
        .in_dd     (dd_s[DD_STAGES]),
        .out_ready (m_axis_tready),
        .en        (en_s[DD_STAGES+1]),
        .out_valid (m_axis_tvalid),
        .res       (res)
    );

    assign s_axis_tready = en_s[0];

    assign m_axis_tuser = {res.fault_class, res.stamp_ok};
    assign m_axis_tdata = {7'd0, res.time_bcd, res.trading_date, res.millis_out,
                           res.second_out, res.minute_out, res.hour_out, res.day_out,
                           res.month_out, res.year_out};

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input blocked while output can move");

endmodule
